FILE: hdl/jsu_pkg.sv
// Shared types, codes and the UTF-8 encoder of the JSON string unescape block.
`default_nettype none

package jsu_pkg;

	// Default number of records held between the decoder and the result sequencer
	localparam int QUEUE_DEPTH = 4;

	// Most result bytes one input byte can produce
	localparam int MAX_BYTES = 6;

	// Result kinds; K_DATA also marks "no terminal result" inside a record
	typedef enum logic [2:0] {
		K_DATA   = 3'd0,
		K_CLOSED = 3'd1,
		K_NOQUOT = 3'd2,
		K_BADESC = 3'd3,
		K_BADHEX = 3'd4,
		K_UNTERM = 3'd5
	} kind_t;

	// Everything one input byte produces: data bytes, then an optional terminal result
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                nd;
		kind_t                     term;
	} rec_t;

	// Queue status seen by the top level and the sequencer
	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	// One encoded code point: up to four bytes, unused bytes are zero
	typedef struct packed {
		logic [3:0][7:0] b;
		logic [2:0]      n;
	} utf8_t;

	// Encode a code point as UTF-8, first byte in b[0]
	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp <= 21'h7F) begin
			r.b[0] = cp[7:0];
			r.n    = 3'd1;
		end else if (cp <= 21'h7FF) begin
			r.b[0] = 8'hC0 | {3'b000, cp[10:6]};
			r.b[1] = 8'h80 | {2'b00, cp[5:0]};
			r.n    = 3'd2;
		end else if (cp <= 21'hFFFF) begin
			r.b[0] = 8'hE0 | {4'b0000, cp[15:12]};
			r.b[1] = 8'h80 | {2'b00, cp[11:6]};
			r.b[2] = 8'h80 | {2'b00, cp[5:0]};
			r.n    = 3'd3;
		end else begin
			r.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
			r.b[1] = 8'h80 | {2'b00, cp[17:12]};
			r.b[2] = 8'h80 | {2'b00, cp[11:6]};
			r.b[3] = 8'h80 | {2'b00, cp[5:0]};
			r.n    = 3'd4;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/jsu_front.sv
// Front end: per-byte string decoder that turns each item into at most one result record.
`default_nettype none

module jsu_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire logic [7:0]  in_byte,
	input  wire logic        end_of_input,
	output jsu_pkg::rec_t    rec,
	output logic             wr
);

	typedef enum logic [6:0] {
		P_WAIT   = 7'b0000001,
		P_STR    = 7'b0000010,
		P_ESC    = 7'b0000100,
		P_HEX    = 7'b0001000,
		P_SUR_BS = 7'b0010000,
		P_SUR_U  = 7'b0100000,
		P_HEX_LO = 7'b1000000
	} phase_t;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;

	phase_t        phase_q, phase_d;
	logic [15:0]   hex_accum_q, hex_accum_d;
	logic [1:0]    hex_count_q, hex_count_d;
	logic [15:0]   held_q, held_d;

	logic          digit_ok;
	logic [3:0]    digit_val;
	logic [15:0]   accum_shift;
	logic          hex_done;
	logic          esc_ok;
	logic [7:0]    esc_char;
	logic [20:0]   pair_cp;

	logic          a_en;
	logic [20:0]   a_cp;
	logic          b_en;
	logic          b_raw;
	logic [15:0]   b_val;
	jsu_pkg::kind_t term;
	jsu_pkg::kind_t term_f;
	logic          keep_data;
	jsu_pkg::utf8_t seg_a, seg_b;
	logic [47:0]   byte_flat;

	// Decode one hex digit in either case
	always_comb begin
		digit_ok  = 1'b1;
		digit_val = 4'd0;
		if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
			digit_val = 4'(in_byte - 8'h30);
		end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
			digit_val = 4'(in_byte - 8'h57);
		end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
			digit_val = 4'(in_byte - 8'h37);
		end else begin
			digit_ok = 1'b0;
		end
	end

	assign accum_shift = {hex_accum_q[11:0], digit_val};
	assign hex_done    = digit_ok && (hex_count_q == 2'd3);
	assign pair_cp     = {1'b0, held_q[9:0], accum_shift[9:0]} + 21'h10000;

	// Map a simple escape letter to its character
	always_comb begin
		esc_ok   = 1'b1;
		esc_char = in_byte;
		unique case (in_byte)
			8'h22, 8'h5C, 8'h2F: esc_char = in_byte;
			8'h62:               esc_char = 8'h08;
			8'h66:               esc_char = 8'h0C;
			8'h6E:               esc_char = 8'h0A;
			8'h72:               esc_char = 8'h0D;
			8'h74:               esc_char = 8'h09;
			default:             esc_ok   = 1'b0;
		endcase
	end

	// Next state and the two output segments for this byte
	always_comb begin
		phase_d     = phase_q;
		hex_accum_d = hex_accum_q;
		hex_count_d = hex_count_q;
		held_d      = held_q;
		term        = jsu_pkg::K_DATA;
		a_en        = 1'b0;
		a_cp        = {5'b0, held_q};
		b_en        = 1'b0;
		b_raw       = 1'b1;
		b_val       = {8'h00, in_byte};
		unique case (phase_q)
			P_STR: begin
				if (in_byte == CH_QUOTE) begin
					term = jsu_pkg::K_CLOSED;
				end else if (in_byte == CH_BSL) begin
					phase_d = P_ESC;
				end else begin
					b_en = 1'b1;
				end
			end
			P_ESC: begin
				phase_d = P_STR;
				if (in_byte == CH_U) begin
					phase_d     = P_HEX;
					hex_accum_d = '0;
					hex_count_d = '0;
				end else if (esc_ok) begin
					b_en  = 1'b1;
					b_val = {8'h00, esc_char};
				end else begin
					term = jsu_pkg::K_BADESC;
				end
			end
			P_HEX: begin
				if (!digit_ok) begin
					term = jsu_pkg::K_BADHEX;
				end else begin
					hex_accum_d = accum_shift;
					hex_count_d = hex_count_q + 2'd1;
					if (hex_done) begin
						if (accum_shift >= 16'hD800 && accum_shift <= 16'hDBFF) begin
							held_d  = accum_shift;
							phase_d = P_SUR_BS;
						end else begin
							a_en    = 1'b1;
							a_cp    = {5'b0, accum_shift};
							phase_d = P_STR;
						end
					end
				end
			end
			P_SUR_BS: begin
				if (in_byte == CH_BSL) begin
					phase_d = P_SUR_U;
				end else begin
					// flush the held surrogate, then treat the byte as plain text
					a_en    = 1'b1;
					phase_d = P_STR;
					if (in_byte == CH_QUOTE) begin
						term = jsu_pkg::K_CLOSED;
					end else begin
						b_en = 1'b1;
					end
				end
			end
			P_SUR_U: begin
				if (in_byte == CH_U) begin
					phase_d     = P_HEX_LO;
					hex_accum_d = '0;
					hex_count_d = '0;
				end else begin
					// flush the held surrogate, then treat the byte as an escape letter
					a_en    = 1'b1;
					phase_d = P_STR;
					if (esc_ok) begin
						b_en  = 1'b1;
						b_val = {8'h00, esc_char};
					end else begin
						term = jsu_pkg::K_BADESC;
					end
				end
			end
			P_HEX_LO: begin
				if (!digit_ok) begin
					term = jsu_pkg::K_BADHEX;
				end else begin
					hex_accum_d = accum_shift;
					hex_count_d = hex_count_q + 2'd1;
					if (hex_done) begin
						phase_d = P_STR;
						a_en    = 1'b1;
						if (accum_shift >= 16'hDC00 && accum_shift <= 16'hDFFF) begin
							a_cp = pair_cp;
						end else begin
							b_en  = 1'b1;
							b_raw = 1'b0;
							b_val = accum_shift;
						end
					end
				end
			end
			default: begin
				if (in_byte == CH_QUOTE) begin
					phase_d = P_STR;
				end else begin
					term = jsu_pkg::K_NOQUOT;
				end
			end
		endcase

		// Unterminated only when the byte itself gave no terminal result
		term_f = term;
		if (term == jsu_pkg::K_DATA && end_of_input) begin
			term_f = jsu_pkg::K_UNTERM;
		end
		if (term_f != jsu_pkg::K_DATA) begin
			phase_d     = P_WAIT;
			hex_accum_d = '0;
			hex_count_d = '0;
			held_d      = '0;
		end
	end

	assign keep_data = (term_f == jsu_pkg::K_DATA) || (term_f == jsu_pkg::K_CLOSED);

	// Encode the segments; the second one is either raw or a 16-bit code point
	always_comb begin
		seg_a = '0;
		seg_b = '0;
		if (a_en && keep_data) begin
			seg_a = jsu_pkg::utf8_enc(a_cp);
		end
		if (b_en && keep_data) begin
			if (b_raw) begin
				seg_b.b[0] = b_val[7:0];
				seg_b.n    = 3'd1;
			end else begin
				seg_b = jsu_pkg::utf8_enc({5'b0, b_val});
			end
		end
	end

	// Pack segment B right behind segment A
	assign byte_flat = {16'h0000, seg_a.b} | ({16'h0000, seg_b.b} << {seg_a.n, 3'b000});

	assign rec.bytes = byte_flat;
	assign rec.nd    = seg_a.n + seg_b.n;
	assign rec.term  = term_f;
	assign wr        = accept && ((rec.nd != 3'd0) || (term_f != jsu_pkg::K_DATA));

	// Advance the decoder state on each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= P_WAIT;
			hex_accum_q <= '0;
			hex_count_q <= '0;
			held_q      <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			hex_accum_q <= hex_accum_d;
			hex_count_q <= hex_count_d;
			held_q      <= held_d;
		end
	end

endmodule

`default_nettype wire

FILE: hdl/jsu_queue.sv
// Short record queue between the decoder and the result sequencer.
`default_nettype none

module jsu_queue #(
	parameter int DEPTH = jsu_pkg::QUEUE_DEPTH // two or more
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr,
	input  wire jsu_pkg::rec_t wr_rec,
	input  wire logic          rd,
	output jsu_pkg::rec_t      head,
	output jsu_pkg::q_stat_t   stat
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::rec_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_wr, do_rd;

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign head       = mem_q[rd_ptr_q];

	// Store incoming records
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hdl/jsu_back.sv
// Back end: walks the head record into the output register, one item per cycle when free.
`default_nettype none

module jsu_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire jsu_pkg::rec_t    head,
	input  wire jsu_pkg::q_stat_t stat,
	output logic                  rd,
	input  wire logic             pop,
	output logic                  empty,
	output logic [7:0]            data_byte,
	output logic [2:0]            kind,
	output logic                  last
);

	logic [2:0]      idx_q;
	logic            out_valid_q;
	logic [7:0]      data_q;
	jsu_pkg::kind_t  kind_q;
	logic            last_q;
	logic            load;
	logic            is_data;
	logic [2:0]      total;
	logic            is_last;

	assign total   = head.nd + {2'b00, (head.term != jsu_pkg::K_DATA)};
	assign is_data = (idx_q < head.nd);
	assign is_last = ((idx_q + 3'd1) == total);
	assign load    = !stat.empty && (!out_valid_q || pop);
	assign rd      = load && is_last;

	// Step through the head record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= is_last ? 3'd0 : idx_q + 3'd1;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the next result item
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= is_data ? head.bytes[idx_q] : 8'h00;
			kind_q <= is_data ? jsu_pkg::K_DATA : head.term;
			last_q <= is_last;
		end
	end

	assign empty     = !out_valid_q;
	assign data_byte = data_q;
	assign kind      = kind_q;
	assign last      = last_q;

endmodule

`default_nettype wire

FILE: hdl/json_string_unescape.sv
// An item's results pass through the record queue and then the output register to the ports.
// Throughput: one item per cycle while the record queue has room; results leave at one
//   per cycle while the output register is empty or popped.
// The queue holds QUEUE_DEPTH records; full is high only when all of them are taken.
// Reset: arst_n clears the decoder to awaiting the opening quote and empties the queue
//   and the output register at once.
`default_nettype none

module json_string_unescape #(
	parameter int QUEUE_DEPTH = jsu_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      data_byte,
	output logic [2:0]      kind,
	output logic            last
);

	logic             accept;
	logic             q_wr;
	logic             q_rd;
	jsu_pkg::rec_t    q_in;
	jsu_pkg::rec_t    q_head;
	jsu_pkg::q_stat_t q_stat;

	assign full   = q_stat.full;
	assign accept = push && !q_stat.full;

	jsu_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.rec          (q_in),
		.wr           (q_wr)
	);

	jsu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_rec (q_in),
		.rd     (q_rd),
		.head   (q_head),
		.stat   (q_stat)
	);

	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.stat      (q_stat),
		.rd        (q_rd),
		.pop       (pop),
		.empty     (empty),
		.data_byte (data_byte),
		.kind      (kind),
		.last      (last)
	);

`ifndef SYNTH
	// Nothing appears on the output without a queued record
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && q_stat.empty && !q_wr) |=> empty)
		else $error("result appeared with nothing queued");

	// A terminal result always ends its item
	a_term_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != jsu_pkg::K_DATA) |-> last)
		else $error("terminal result without last");

	// A terminal result carries a zero data byte
	a_term_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind != jsu_pkg::K_DATA) |-> (data_byte == 8'h00))
		else $error("terminal result with nonzero data");

	// The decoder never writes into a full queue
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		q_stat.full |-> !q_wr)
		else $error("record written into full queue");
`endif

endmodule

`default_nettype wire
